FILE: hw/rtl/lru_translation_lookaside_buffer_core_defines.svh
// Assertion macros shared by the translation buffer RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef LRU_TRANSLATION_LOOKASIDE_BUFFER_CORE_DEFINES_SVH
`define LRU_TRANSLATION_LOOKASIDE_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define LRUTLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define LRUTLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lrutlb_pkg.sv
// Package for the translation buffer: sizes, action and status codes, result type.
// No dependencies.
package lrutlb_pkg;

  localparam int ENTRIES    = 32;
  localparam int PAGE_BITS  = 20;
  localparam int FRAME_BITS = 20;
  localparam int RANK_BITS  = $clog2(ENTRIES);
  localparam int CNT_BITS   = $clog2(ENTRIES + 1);

  // Action codes; the fourth code means nothing and fails.
  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic                  status;
    logic [FRAME_BITS-1:0] frame_out;
    logic [PAGE_BITS-1:0]  lru_page;
    logic                  lru_valid;
    logic [CNT_BITS-1:0]   count;
  } res_t;

endpackage

FILE: hw/rtl/lrutlb_if.sv
// Valid/ready channel interfaces for the translation buffer's request and result words.
// Depends on lrutlb_pkg.
interface lrutlb_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        action;
  logic [lrutlb_pkg::PAGE_BITS-1:0]  page;
  logic [lrutlb_pkg::FRAME_BITS-1:0] frame;

  modport source (output valid, action, page, frame, input ready);
  modport sink   (input valid, action, page, frame, output ready);
endinterface

interface lrutlb_out_if;
  logic                              valid;
  logic                              ready;
  logic                              status;
  logic [lrutlb_pkg::FRAME_BITS-1:0] frame_out;
  logic [lrutlb_pkg::PAGE_BITS-1:0]  lru_page;
  logic                              lru_valid;
  logic [lrutlb_pkg::CNT_BITS-1:0]   count;

  modport source (output valid, status, frame_out, lru_page, lru_valid, count,
                  input ready);
  modport sink   (input valid, status, frame_out, lru_page, lru_valid, count,
                  output ready);
endinterface

FILE: hw/rtl/lru_translation_lookaside_buffer_core.sv
// Fully associative 32-entry translation buffer with least-recently-used order.
// A request word is captured in an input register; the tag compare, rank update
// and LRU pick run combinationally into a result register. One word per cycle is
// sustained while the result side accepts every result; a word waits in the
// input register while the result register holds a result not yet taken. Each
// result carries the status, the hit frame, the entry count and the least
// recently used page after the action. Depends on lrutlb_pkg, lrutlb_if and
// lru_translation_lookaside_buffer_core_defines.svh.
`include "lru_translation_lookaside_buffer_core_defines.svh"

module lru_translation_lookaside_buffer_core (
  input  logic                clk,
  input  logic                rst_n,
  lrutlb_in_if.sink           in_ch,
  lrutlb_out_if.source        out_ch
);

  localparam int N  = lrutlb_pkg::ENTRIES;
  localparam int PB = lrutlb_pkg::PAGE_BITS;
  localparam int FB = lrutlb_pkg::FRAME_BITS;
  localparam int RB = lrutlb_pkg::RANK_BITS;
  localparam int CB = lrutlb_pkg::CNT_BITS;

  // Input stage
  logic          s1_vld_r;
  logic [1:0]    act_r;
  logic [PB-1:0] page_r;
  logic [FB-1:0] frame_r;

  // Buffer state
  logic [N-1:0]  valid_r, valid_nxt;
  logic [PB-1:0] page_mem_r  [N];
  logic [PB-1:0] page_mem_nxt [N];
  logic [FB-1:0] frame_mem_r [N];
  logic [FB-1:0] frame_mem_nxt [N];
  logic [RB-1:0] rank_r [N];
  logic [RB-1:0] rank_nxt [N];
  logic [CB-1:0] cnt_r, cnt_nxt;

  // Result stage
  logic              out_vld_r;
  lrutlb_pkg::res_t  res_r, res_nxt;

  logic          advance;
  logic          in_fire;
  logic [N-1:0]  hit_vec;
  logic          hit;
  logic [RB-1:0] hit_rank;
  logic [FB-1:0] hit_frame;
  logic [N-1:0]  free_vec;
  logic [N-1:0]  free_oh;
  logic          not_full;
  logic          do_promote, do_insert, do_remove, do_wr_frame;
  logic          status;
  logic [FB-1:0] frame_out;
  logic [RB-1:0] lru_rank;
  logic [PB-1:0] lru_page;
  logic          fail_out;

  // Handshake: the input stage moves on whenever the result register is free.
  assign advance      = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !s1_vld_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Parallel tag compare; at most one entry holds a given page.
  always_comb begin
    hit_vec   = '0;
    hit_rank  = '0;
    hit_frame = '0;
    for (int i = 0; i < N; i++) begin
      hit_vec[i] = valid_r[i] && (page_mem_r[i] == page_r);
      hit_rank   = hit_rank  | (hit_vec[i] ? rank_r[i] : '0);
      hit_frame  = hit_frame | (hit_vec[i] ? frame_mem_r[i] : '0);
    end
  end
  assign hit = |hit_vec;

  // Lowest free slot as a one-hot vector.
  assign free_vec = ~valid_r;
  assign free_oh  = free_vec & (~free_vec + N'(1));
  assign not_full = cnt_r < CB'(N);

  // Action decode.
  always_comb begin
    do_promote  = 1'b0;
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    do_wr_frame = 1'b0;
    status      = lrutlb_pkg::STATUS_FAIL;
    frame_out   = '0;
    unique case (act_r)
      lrutlb_pkg::ACT_LOOKUP: begin
        if (hit) begin
          do_promote = 1'b1;
          status     = lrutlb_pkg::STATUS_OK;
          frame_out  = hit_frame;
        end
      end
      lrutlb_pkg::ACT_ADD: begin
        if (hit) begin
          // Re-add of a held page: new frame, entry becomes most recent.
          do_promote  = 1'b1;
          do_wr_frame = 1'b1;
          status      = lrutlb_pkg::STATUS_OK;
        end else if (not_full) begin
          do_insert = 1'b1;
          status    = lrutlb_pkg::STATUS_OK;
        end
      end
      lrutlb_pkg::ACT_FLUSH: begin
        if (hit) begin
          do_remove = 1'b1;
          status    = lrutlb_pkg::STATUS_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // Per-entry next state: validity, rank and stored pair.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid_nxt[i]     = valid_r[i];
      rank_nxt[i]      = rank_r[i];
      page_mem_nxt[i]  = page_mem_r[i];
      frame_mem_nxt[i] = frame_mem_r[i];
      if (do_promote) begin
        if (hit_vec[i]) begin
          rank_nxt[i] = '0;
          if (do_wr_frame) begin
            frame_mem_nxt[i] = frame_r;
          end
        end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + RB'(1);
        end
      end
      if (do_insert) begin
        if (free_oh[i]) begin
          valid_nxt[i]     = 1'b1;
          rank_nxt[i]      = '0;
          page_mem_nxt[i]  = page_r;
          frame_mem_nxt[i] = frame_r;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + RB'(1);
        end
      end
      if (do_remove) begin
        if (hit_vec[i]) begin
          valid_nxt[i] = 1'b0;
        end else if (valid_r[i] && (rank_r[i] > hit_rank)) begin
          rank_nxt[i] = rank_r[i] - RB'(1);
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_insert) begin
      cnt_nxt = cnt_r + CB'(1);
    end else if (do_remove) begin
      cnt_nxt = cnt_r - CB'(1);
    end
  end

  // Least recently used entry after the action holds rank count-1.
  assign lru_rank = RB'(cnt_nxt - CB'(1));

  always_comb begin
    lru_page = '0;
    for (int i = 0; i < N; i++) begin
      if (valid_nxt[i] && (rank_nxt[i] == lru_rank)) begin
        lru_page = lru_page | page_mem_nxt[i];
      end
    end
  end

  always_comb begin
    res_nxt.status    = status;
    res_nxt.frame_out = frame_out;
    res_nxt.lru_valid = cnt_nxt != '0;
    res_nxt.lru_page  = (cnt_nxt != '0) ? lru_page : '0;
    res_nxt.count     = cnt_nxt;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r   <= in_ch.action;
      page_r  <= in_ch.page;
      frame_r <= in_ch.frame;
    end
  end

  // Buffer state registers; they change only when a word completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
    end else if (advance) begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < N; i++) begin
        rank_r[i]      <= rank_nxt[i];
        page_mem_r[i]  <= page_mem_nxt[i];
        frame_mem_r[i] <= frame_mem_nxt[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.status    = res_r.status;
  assign out_ch.frame_out = res_r.frame_out;
  assign out_ch.lru_page  = res_r.lru_page;
  assign out_ch.lru_valid = res_r.lru_valid;
  assign out_ch.count     = res_r.count;

  // A failed action is being presented.
  assign fail_out = out_vld_r && (res_r.status == lrutlb_pkg::STATUS_FAIL);

  // Checks on the buffer's own bookkeeping.
  `LRUTLB_ASSERT_NOW(a_cnt_matches_valid, 1'b1, $countones(valid_r) == int'(cnt_r), "bad count")
  `LRUTLB_ASSERT_NOW(a_hit_unique, s1_vld_r, $onehot0(hit_vec), "page held twice")
  `LRUTLB_ASSERT_NEXT(a_state_holds, !advance, $stable(valid_r) && $stable(cnt_r), "state moved")
  `LRUTLB_ASSERT_NOW(a_lru_flag, out_vld_r, res_r.lru_valid == (res_r.count != '0), "LRU flag")
  `LRUTLB_ASSERT_NOW(a_fail_no_frame, fail_out, res_r.frame_out == '0, "frame on fail")

endmodule

FILE: tb/lru_translation_lookaside_buffer_core_checker.sv
`timescale 1ns / 1ps
// Result checker for the translation buffer: watches the request and result channels,
// keeps its own copy of entries and recency ranks, and compares every result word.
// Depends on lrutlb_pkg and the channel interfaces in lrutlb_if.
module lru_translation_lookaside_buffer_core_checker
  import lrutlb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  lrutlb_in_if  req,
  lrutlb_out_if rsp,
  output int    mismatches,
  output int    pending_words
);

  // Shadow copy of the buffer contents. Rank 0 is the most recent entry.
  logic                  held_valid [ENTRIES];
  logic [PAGE_BITS-1:0]  held_page  [ENTRIES];
  logic [FRAME_BITS-1:0] held_frame [ENTRIES];
  int                    held_rank  [ENTRIES];
  int                    held_count;

  // Result words still owed by the block, oldest first.
  res_t                  owed_results [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int find_page(input logic [PAGE_BITS-1:0] p);
    for (int i = 0; i < ENTRIES; i++) begin
      if (held_valid[i] && held_page[i] == p) return i;
    end
    return -1;
  endfunction

  // Move one entry to the front; only entries younger than it get older.
  function automatic void make_most_recent(input int s);
    int r;
    r = held_rank[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (held_valid[i] && i != s && held_rank[i] < r) held_rank[i]++;
    end
    held_rank[s] = 0;
  endfunction

  // Apply one request word to the shadow state and return the result it produces.
  function automatic res_t translate(input logic [1:0] act, input logic [PAGE_BITS-1:0] p,
                                     input logic [FRAME_BITS-1:0] f);
    res_t res;
    int   hit;
    int   slot;
    int   r;
    res        = '0;
    res.status = STATUS_FAIL;
    hit        = find_page(p);
    case (act)
      ACT_LOOKUP: begin
        if (hit >= 0) begin
          res.frame_out = held_frame[hit];
          make_most_recent(hit);
          res.status = STATUS_OK;
        end
      end
      ACT_ADD: begin
        if (hit >= 0) begin
          // A page already held takes the new frame, even when the buffer is full.
          held_frame[hit] = f;
          make_most_recent(hit);
          res.status = STATUS_OK;
        end else if (held_count < ENTRIES) begin
          slot = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!held_valid[i] && slot < 0) slot = i;
          end
          if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (held_valid[i]) held_rank[i]++;
            end
            held_valid[slot] = 1'b1;
            held_page[slot]  = p;
            held_frame[slot] = f;
            held_rank[slot]  = 0;
            held_count++;
            res.status = STATUS_OK;
          end
        end
      end
      ACT_FLUSH: begin
        if (hit >= 0) begin
          r = held_rank[hit];
          held_valid[hit] = 1'b0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (held_valid[i] && held_rank[i] > r) held_rank[i]--;
          end
          if (held_count > 0) held_count--;
          res.status = STATUS_OK;
        end
      end
      default: ;
    endcase

    // The oldest entry carries the highest rank, count minus one.
    for (int i = 0; i < ENTRIES; i++) begin
      if (!res.lru_valid && held_count > 0 && held_valid[i] &&
          held_rank[i] == held_count - 1) begin
        res.lru_page  = held_page[i];
        res.lru_valid = 1'b1;
      end
    end
    res.count = CNT_BITS'(held_count);
    return res;
  endfunction

  // Predict on every accepted request first, then compare an accepted result.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        held_valid[i] = 1'b0;
        held_page[i]  = '0;
        held_frame[i] = '0;
        held_rank[i]  = 0;
      end
      held_count = 0;
      owed_results.delete();
      mismatches = 0;
      pending_words <= 0;
    end else begin
      if (req.valid && req.ready) begin
        owed_results.push_back(translate(req.action, req.page, req.frame));
      end
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result word arrived with no request waiting");
        end else begin
          want = owed_results.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0h, expected %0h", rsp.status, want.status));
          if (rsp.frame_out !== want.frame_out)
            report_mismatch($sformatf("frame_out %05h, expected %05h",
                                      rsp.frame_out, want.frame_out));
          if (rsp.lru_page !== want.lru_page)
            report_mismatch($sformatf("lru_page %05h, expected %05h",
                                      rsp.lru_page, want.lru_page));
          if (rsp.lru_valid !== want.lru_valid)
            report_mismatch($sformatf("lru_valid %0h, expected %0h",
                                      rsp.lru_valid, want.lru_valid));
          if (rsp.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", rsp.count, want.count));
        end
      end
      pending_words <= owed_results.size();
    end
  end

endmodule

FILE: tb/lru_translation_lookaside_buffer_core_tb.sv
`timescale 1ns / 1ps
// Top of the translation buffer testbench: clock, reset, request stimulus, result
// back-pressure, stall watchdog and verdict. Depends on lrutlb_pkg, lrutlb_if, the
// buffer RTL and lru_translation_lookaside_buffer_core_checker.
module lru_translation_lookaside_buffer_core_tb;
  import lrutlb_pkg::*;

  // The fourth action code has no meaning; the block must reject it.
  localparam logic [1:0] ACT_NONE     = 2'd3;
  localparam int         PHASE_ITEMS  = 125;
  localparam int         BLOCK_ITEMS  = 70;
  localparam int         LIST_DEPTH   = 64;
  localparam int         STALL_LIMIT  = 1000;
  localparam int         DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;
  int   sender_gap_pct;
  int   sink_stall_pct;
  int   mismatches;
  int   pending_words;
  int   quiet_cycles = 0;

  // Pages sent with an add, so that lookups and flushes mostly hit.
  logic [PAGE_BITS-1:0] added_pages [$];

  lrutlb_in_if  req_ch ();
  lrutlb_out_if rsp_ch ();

  lru_translation_lookaside_buffer_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  lru_translation_lookaside_buffer_core_checker result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: too long without any word accepted on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("lru_translation_lookaside_buffer_core_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request word, with random idle cycles ahead of it.
  task automatic send_word(input logic [1:0] act, input logic [PAGE_BITS-1:0] p,
                           input logic [FRAME_BITS-1:0] f);
    while ($urandom_range(99) < sender_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.page   <= p;
    req_ch.frame  <= f;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Hold off the request side until every result word has come back.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // Random traffic: a filling block that drives the buffer full, then a draining
  // block that flushes it back toward empty. A tenth of the pages are noise.
  task automatic run_phase(input int gap_pct, input int stall_pct, input int items);
    int                   sent;
    int                   pick;
    int                   add_pct;
    int                   flush_pct;
    int                   idx;
    logic [1:0]           act;
    logic [PAGE_BITS-1:0] p;
    sender_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      add_pct   = ((sent / BLOCK_ITEMS) % 2 == 0) ? 70 : 5;
      flush_pct = 75 - add_pct;
      pick = $urandom_range(99);
      if (pick < 4) act = ACT_NONE;
      else if (pick < 4 + add_pct) act = ACT_ADD;
      else if (pick < 4 + add_pct + flush_pct) act = ACT_FLUSH;
      else act = ACT_LOOKUP;

      p = PAGE_BITS'($urandom);
      if (act == ACT_ADD) begin
        // Now and then re-add a page that may still be held.
        if (added_pages.size() > 0 && $urandom_range(99) < 15) begin
          p = added_pages[$urandom_range(added_pages.size() - 1)];
        end else begin
          added_pages.push_back(p);
          if (added_pages.size() > LIST_DEPTH) void'(added_pages.pop_front());
        end
      end else if (act != ACT_NONE && added_pages.size() > 0 &&
                   $urandom_range(99) >= 10) begin
        idx = $urandom_range(added_pages.size() - 1);
        p   = added_pages[idx];
        if (act == ACT_FLUSH) added_pages.delete(idx);
      end

      send_word(act, p, FRAME_BITS'($urandom));
      if (act != ACT_NONE) sent++;
      if ($urandom_range(199) == 0) wait_for_results();
    end
  endtask

  initial begin
    sender_gap_pct = 0;
    sink_stall_pct = 0;
    rst_n          <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.action  <= ACT_LOOKUP;
    req_ch.page    <= '0;
    req_ch.frame   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty buffer, extremes, promotion, re-add, slot reuse, emptying.
    send_word(ACT_LOOKUP, 20'h00000, 20'h00000);
    send_word(ACT_FLUSH,  20'hFFFFF, 20'hFFFFF);
    send_word(ACT_NONE,   20'hFFFFF, 20'hFFFFF);
    send_word(ACT_ADD,    20'h00000, 20'hFFFFF);
    send_word(ACT_ADD,    20'hFFFFF, 20'h00000);
    send_word(ACT_ADD,    20'h12345, 20'hABCDE);
    send_word(ACT_LOOKUP, 20'hFFFFF, 20'h12345);
    send_word(ACT_LOOKUP, 20'h00000, 20'h00000);
    send_word(ACT_LOOKUP, 20'h00000, 20'hFFFFF);
    send_word(ACT_LOOKUP, 20'h55555, 20'h00000);
    send_word(ACT_ADD,    20'h00000, 20'h00001);
    send_word(ACT_NONE,   20'h00000, 20'h00000);
    send_word(ACT_FLUSH,  20'h12345, 20'h00000);
    send_word(ACT_ADD,    20'hAAAAA, 20'h55555);
    send_word(ACT_FLUSH,  20'h00000, 20'h00000);
    send_word(ACT_ADD,    20'hF0F0F, 20'h0F0F0);
    send_word(ACT_FLUSH,  20'hFFFFF, 20'h00000);
    send_word(ACT_FLUSH,  20'hAAAAA, 20'h00000);
    send_word(ACT_FLUSH,  20'hF0F0F, 20'h00000);
    wait_for_results();

    // Random traffic under three idling mixes, drained between them.
    run_phase(7, 54, PHASE_ITEMS);
    wait_for_results();
    run_phase(54, 7, PHASE_ITEMS);
    wait_for_results();
    run_phase(0, 0, PHASE_ITEMS);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_words == 0) begin
      $display("lru_translation_lookaside_buffer_core_tb OK");
    end else begin
      $display("lru_translation_lookaside_buffer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
